// File: sv/wroc_pkg.sv
// Shared types, widths and codes for the window raster-op compositor.
// No dependencies; every other file imports this package.
package wroc_pkg;

  localparam int ADDR_W     = 24;  // framebuffer pixel index
  localparam int POS_W      = 12;  // window_x / window_y
  localparam int SIZE_W     = 13;  // window and screen sizes
  localparam int MODE_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam int DEF_MAX_DIMENSION = 4096;
  localparam int DEF_PIXEL_BITS    = 32;

  localparam logic [31:0] KEY_PIXEL = 32'hfefe_fefe;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OVERLAP_MODE  = 3'd5;

  typedef enum logic [MODE_W-1:0] {
    ROP_DIRECT = 8'd0,
    ROP_INSET  = 8'd1,
    ROP_OR     = 8'd2,
    ROP_XOR    = 8'd3,
    ROP_INVERT = 8'd4,
    ROP_SELECT = 8'd5,
    ROP_AND    = 8'd6
  } rop_mode_t;

  // Settled configuration handed to the scan counters and the result stage
  typedef struct packed {
    logic [ADDR_W-1:0] origin;       // window_y*screen_width + window_x
    logic [SIZE_W-1:0] screen_width;
    logic [SIZE_W-1:0] last_col;     // clamped width - 1
    logic [SIZE_W-1:0] last_row;     // clamped height - 1
    logic [MODE_W-1:0] mode;
  } cfg_t;

  // Scan position of the item being accepted
  typedef struct packed {
    logic [ADDR_W-1:0] col_addr;
    logic [ADDR_W-1:0] row_base;
    logic              end_col;
    logic              end_row;
  } scan_t;

endpackage

// File: sv/wroc_cfg.sv
// Configuration registers, size clamping and the registered window origin.
// Depends on wroc_pkg.
module wroc_cfg #(
  parameter int MAX_DIMENSION = wroc_pkg::DEF_MAX_DIMENSION
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [wroc_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [wroc_pkg::CFG_DATA_W-1:0] wr_data,
  output wroc_pkg::cfg_t                 cfg,
  output logic                           settling
);
  import wroc_pkg::*;

  localparam logic [SIZE_W-1:0] MAX_SIZE = SIZE_W'(MAX_DIMENSION);

  logic [POS_W-1:0]  window_x_r, window_y_r;
  logic [SIZE_W-1:0] window_width_r, window_height_r, screen_width_r;
  logic [MODE_W-1:0] mode_r;
  logic [ADDR_W-1:0] prod_r, origin_r;
  logic [1:0]        hold_r, hold_nxt;
  logic [2*SIZE_W-1:0] prod_full;

  function automatic logic [SIZE_W-1:0] last_index(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] c;
    if (v == '0) c = SIZE_W'(1);
    else if (v > MAX_SIZE) c = MAX_SIZE;
    else c = v;
    return c - SIZE_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_x_r      <= '0;
      window_y_r      <= '0;
      window_width_r  <= SIZE_W'(1);
      window_height_r <= SIZE_W'(1);
      screen_width_r  <= SIZE_W'(4096);
      mode_r          <= ROP_DIRECT;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_WINDOW_X:      window_x_r      <= wr_data[POS_W-1:0];
        REG_WINDOW_Y:      window_y_r      <= wr_data[POS_W-1:0];
        REG_WINDOW_WIDTH:  window_width_r  <= wr_data[SIZE_W-1:0];
        REG_WINDOW_HEIGHT: window_height_r <= wr_data[SIZE_W-1:0];
        REG_SCREEN_WIDTH:  screen_width_r  <= wr_data[SIZE_W-1:0];
        REG_OVERLAP_MODE:  mode_r          <= wr_data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // origin settles through a registered product, then a registered add, after the last write
  assign prod_full = {1'b0, window_y_r} * screen_width_r;

  always_ff @(posedge clk) begin
    prod_r   <= prod_full[ADDR_W-1:0];
    origin_r <= prod_r + ADDR_W'(window_x_r);
  end

  always_comb begin
    if (wr_en) hold_nxt = 2'd2;
    else if (hold_r != 2'd0) hold_nxt = hold_r - 2'd1;
    else hold_nxt = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) hold_r <= 2'd2;
    else hold_r <= hold_nxt;
  end

  assign settling         = (hold_r != 2'd0);
  assign cfg.origin       = origin_r;
  assign cfg.screen_width = screen_width_r;
  assign cfg.last_col     = last_index(window_width_r);
  assign cfg.last_row     = last_index(window_height_r);
  assign cfg.mode         = mode_r;

endmodule

// File: sv/wroc_scan.sv
// Raster scan counters: column, row and row base address within the window.
// Depends on wroc_pkg.
module wroc_scan #(
  parameter int MAX_DIMENSION = wroc_pkg::DEF_MAX_DIMENSION
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  wroc_pkg::cfg_t  cfg,
  output wroc_pkg::scan_t pos
);
  import wroc_pkg::*;

  localparam int CNT_W = $clog2(MAX_DIMENSION);

  logic [CNT_W-1:0]  col_r, col_nxt, row_r, row_nxt;
  logic [ADDR_W-1:0] row_base_r, row_base_nxt;
  logic              end_col, end_row;

  // a counter past a shrunken size counts as being at the last index
  assign end_col = SIZE_W'(col_r) >= cfg.last_col;
  assign end_row = SIZE_W'(row_r) >= cfg.last_row;

  always_comb begin
    col_nxt      = col_r;
    row_nxt      = row_r;
    row_base_nxt = row_base_r;
    if (step) begin
      if (!end_col) begin
        col_nxt = col_r + CNT_W'(1);
      end else begin
        col_nxt = '0;
        if (end_row) begin
          row_nxt      = '0;
          row_base_nxt = '0;
        end else begin
          row_nxt      = row_r + CNT_W'(1);
          row_base_nxt = row_base_r + ADDR_W'(cfg.screen_width);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      row_base_r <= '0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      row_base_r <= row_base_nxt;
    end
  end

  assign pos.col_addr = ADDR_W'(col_r);
  assign pos.row_base = row_base_r;
  assign pos.end_col  = end_col;
  assign pos.end_row  = end_row;

`ifndef SYNTH
  a_row_base_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (row_r == '0) |-> (row_base_r == '0))
    else $error("row base nonzero on first row");
`endif

endmodule

// File: sv/wroc_rop.sv
// Raster operation on one pixel pair: new value and write flag per mode.
// Depends on wroc_pkg.
module wroc_rop #(
  parameter int PIXEL_BITS = wroc_pkg::DEF_PIXEL_BITS
) (
  input  logic [wroc_pkg::MODE_W-1:0] mode,
  input  logic [PIXEL_BITS-1:0]       fg,
  input  logic [PIXEL_BITS-1:0]       bg,
  output logic [PIXEL_BITS-1:0]       val,
  output logic                        we
);
  import wroc_pkg::*;

  localparam logic [PIXEL_BITS-1:0] KEY = KEY_PIXEL[PIXEL_BITS-1:0];

  logic fg_zero;
  assign fg_zero = (fg == '0);

  always_comb begin
    val = bg;
    we  = 1'b0;
    unique case (mode)
      ROP_DIRECT: begin val = fg;      we = 1'b1; end
      ROP_OR:     begin val = fg | bg; we = 1'b1; end
      ROP_XOR:    begin val = fg ^ bg; we = 1'b1; end
      ROP_AND:    begin val = fg & bg; we = 1'b1; end
      ROP_INVERT: begin
        if (!fg_zero) begin val = ~bg; we = 1'b1; end
      end
      ROP_SELECT: begin
        if (fg_zero) begin val = '0; we = 1'b1; end
      end
      default: begin
        // keyed inset; unknown modes behave the same
        if (!fg_zero && fg != KEY) begin val = fg; we = 1'b1; end
      end
    endcase
  end

endmodule

// File: sv/window_raster_op_compositor.sv
// Window raster-op compositor: blends a window's pixels into a framebuffer.
// Input stream: in_tdata = {bg_pixel, fg_pixel}, one window pixel per item in
//   raster order together with the framebuffer pixel under it.
// Output stream: out_tdata = {new_pixel, fb_address}, out_tuser = write_enable,
//   out_tlast = last pixel of the window. One result per input item.
// Config channel: cfg_index/cfg_data, always ready; indexes 0..5 are
//   window_x, window_y, window_width, window_height, screen_width, overlap_mode.
// Pipeline: input register, then result register. Throughput: one item per cycle
//   while the receiver is ready and no config write settles, since the raster
//   op and the address add sit in one stage between the two registers.
// After a config write, and after reset, in_tready drops while the window origin
//   (window_y*screen_width + window_x) is recomputed through its registered
//   multiplier.
// Reset (synchronous, rst_n low) clears the scan counters, the pipeline valids
//   and restores register defaults. A stalled receiver holds the result
//   register; the input register keeps accepting until it is also full, then
//   in_tready falls, so no item is dropped.
// Depends on wroc_pkg, wroc_cfg, wroc_scan, wroc_rop.
module window_raster_op_compositor #(
  parameter int MAX_DIMENSION = wroc_pkg::DEF_MAX_DIMENSION,
  parameter int PIXEL_BITS    = wroc_pkg::DEF_PIXEL_BITS
) (
  input  logic clk,
  input  logic rst_n,
  // in_tdata: fg_pixel, bg_pixel (from bit 0 up), zero padded
  input  logic                                      in_tvalid,
  output logic                                      in_tready,
  input  logic [((2*PIXEL_BITS+7)/8)*8-1:0]         in_tdata,
  // out_tdata: fb_address, new_pixel (from bit 0 up), zero padded
  output logic                                      out_tvalid,
  input  logic                                      out_tready,
  output logic [((wroc_pkg::ADDR_W+PIXEL_BITS+7)/8)*8-1:0] out_tdata,
  // out_tuser: write_enable
  output logic                                      out_tuser,
  output logic                                      out_tlast,
  input  logic                                      cfg_valid,
  output logic                                      cfg_ready,
  input  logic [wroc_pkg::CFG_IDX_W-1:0]            cfg_index,
  input  logic [wroc_pkg::CFG_DATA_W-1:0]           cfg_data
);
  import wroc_pkg::*;

  localparam int OUT_W = ((ADDR_W + PIXEL_BITS + 7) / 8) * 8;

  cfg_t  cfg;
  scan_t pos;
  logic  settling;
  logic  in_accept, s1_adv, out_adv;

  logic                  s1_valid_r, s1_valid_nxt;
  logic [PIXEL_BITS-1:0] s1_fg_r, s1_bg_r;
  scan_t                 s1_pos_r;

  logic                  out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]     addr_r;
  logic [PIXEL_BITS-1:0] pixel_r;
  logic                  we_r, last_r;

  logic [PIXEL_BITS-1:0] rop_val;
  logic                  rop_we;
  logic [ADDR_W-1:0]     addr_sum;

  assign cfg_ready = 1'b1;

  wroc_cfg #(.MAX_DIMENSION(MAX_DIMENSION)) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg),
    .settling (settling)
  );

  wroc_scan #(.MAX_DIMENSION(MAX_DIMENSION)) u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (in_accept),
    .cfg   (cfg),
    .pos   (pos)
  );

  // Handshake: each stage moves when the stage after it is empty or draining
  assign out_adv   = !out_valid_r || out_tready;
  assign s1_adv    = !s1_valid_r || out_adv;
  assign in_tready = s1_adv && !settling;
  assign in_accept = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_adv ? in_accept : s1_valid_r;
    out_valid_nxt = out_adv ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_fg_r  <= in_tdata[PIXEL_BITS-1:0];
      s1_bg_r  <= in_tdata[2*PIXEL_BITS-1:PIXEL_BITS];
      s1_pos_r <= pos;
    end
  end

  wroc_rop #(.PIXEL_BITS(PIXEL_BITS)) u_rop (
    .mode (cfg.mode),
    .fg   (s1_fg_r),
    .bg   (s1_bg_r),
    .val  (rop_val),
    .we   (rop_we)
  );

  assign addr_sum = cfg.origin + s1_pos_r.row_base + s1_pos_r.col_addr;

  always_ff @(posedge clk) begin
    if (out_adv && s1_valid_r) begin
      addr_r  <= addr_sum;
      pixel_r <= rop_val;
      we_r    <= rop_we;
      last_r  <= s1_pos_r.end_col && s1_pos_r.end_row;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({pixel_r, addr_r});
  assign out_tuser  = we_r;
  assign out_tlast  = last_r;

`ifndef SYNTH
  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready) |=> !in_tready)
    else $error("item accepted while origin recomputes");

  a_one_pixel_window_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && cfg.last_col == '0 && cfg.last_row == '0) |=>
      (s1_pos_r.end_col && s1_pos_r.end_row))
    else $error("single pixel window not marked last");

  a_no_write_keeps_bg: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !rop_we) |-> (rop_val == s1_bg_r))
    else $error("unwritten pixel differs from background");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_adv) |=> s1_valid_r)
    else $error("input register item lost under stall");
`endif

endmodule
